// ===== hw/rtl/tkst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkst_pkg;

    // Number of ranked slots physically held in the table.
    localparam int TABLE_DEPTH = 16;

    // Slot index width and width of a count that can hold TABLE_DEPTH itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Field widths of the transactions and of the configuration register.
    localparam int ID_W    = 16;
    localparam int SCORE_W = 32;
    localparam int POS_W   = 5;
    localparam int MAXE_W  = 5;

    localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic find;
        logic remove;
        logic search;
        logic insert;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic find_end;
        logic find_hit;
        logic srch_end;
        logic srch_hit;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/tkst_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Score update channel.
interface tkst_in_if;
    logic                             valid;
    logic                             ready;
    logic [tkst_pkg::ID_W-1:0]        player_id;
    logic signed [tkst_pkg::SCORE_W-1:0] score;

    modport source (output valid, output player_id, output score, input ready);
    modport sink   (input valid, input player_id, input score, output ready);
endinterface

// Rank report channel.
interface tkst_out_if;
    logic                         valid;
    logic                         ready;
    logic [tkst_pkg::POS_W-1:0]   old_position;
    logic [tkst_pkg::POS_W-1:0]   new_position;
    logic                         added;

    modport source (output valid, output old_position, output new_position, output added,
                    input ready);
    modport sink   (input valid, input old_position, input new_position, input added,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/top_k_score_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted update walks the table for the player's slot up to the table fill,
// removes it, walks for the rank up to max_entries capped at the table depth, inserts
// and trims; its report becomes valid once the previous report has left the output.
// The block takes one update at a time, and the id walk and the rank walk step one slot
// per cycle; the next update is taken while a report waits.
// Reset (synchronous, active low) empties the table and sets max_entries to 10.

module top_k_score_table_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tkst_pkg::MAXE_W-1:0] i_cfg_wdata,
    tkst_in_if.sink                          i_in,
    tkst_out_if.source                       o_out
);

    // The controller sequences each transaction: it walks the table for the
    // player's current slot, removes it, walks again for the insertion point,
    // inserts and trims, and finally hands the report to the output register.
    // The datapath holds the table as a row of slots that shift by one place.

    tkst_pkg::t_cmd w_cmd;
    tkst_pkg::t_sts w_sts;

    tkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The output register in the datapath lets a report wait without holding
    // up the next transaction.
    tkst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_player_id    (i_in.player_id),
        .i_score        (i_in.score),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_old_position (o_out.old_position),
        .o_new_position (o_out.new_position),
        .o_added        (o_out.added)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tkst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tkst_pkg::t_sts i_sts,
    output tkst_pkg::t_cmd     o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FIND   = 6'b000010,
        S_REMOVE = 6'b000100,
        S_SEARCH = 6'b001000,
        S_INSERT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.find_end || i_sts.find_hit) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                o_cmd.remove = 1'b1;
                n_state      = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.srch_end || i_sts.srch_hit) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tkst_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkst_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tkst_pkg::MAXE_W-1:0]         i_cfg_wdata,
    input  wire logic [tkst_pkg::ID_W-1:0]           i_player_id,
    input  wire logic signed [tkst_pkg::SCORE_W-1:0] i_score,
    input  wire tkst_pkg::t_cmd                      i_cmd,
    output tkst_pkg::t_sts                           o_sts,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [tkst_pkg::POS_W-1:0]               o_old_position,
    output logic [tkst_pkg::POS_W-1:0]               o_new_position,
    output logic                                     o_added
);

    localparam int TD    = tkst_pkg::TABLE_DEPTH;
    localparam int IDX_W = tkst_pkg::IDX_W;
    localparam int CNT_W = tkst_pkg::CNT_W;
    localparam int POS_W = tkst_pkg::POS_W;

    logic [tkst_pkg::MAXE_W-1:0]         r_max_entries;

    // Ranked table, slot 0 holds the highest score.
    logic [tkst_pkg::ID_W-1:0]           r_ids    [TD];
    logic signed [tkst_pkg::SCORE_W-1:0] r_scores [TD];
    logic [tkst_pkg::ID_W-1:0]           n_ids    [TD];
    logic signed [tkst_pkg::SCORE_W-1:0] n_scores [TD];
    logic [CNT_W-1:0]                    r_count;

    // Transaction being worked on.
    logic [tkst_pkg::ID_W-1:0]           r_id;
    logic signed [tkst_pkg::SCORE_W-1:0] r_score;
    logic [CNT_W-1:0]                    r_lim;
    logic [CNT_W-1:0]                    r_idx;
    logic                                r_found;
    logic [IDX_W-1:0]                    r_fidx;
    logic                                r_placed;
    logic [IDX_W-1:0]                    r_pos;
    logic [CNT_W-1:0]                    r_new_rank;

    // Result register.
    logic                                r_res_valid;
    logic [POS_W-1:0]                    r_res_old;
    logic [POS_W-1:0]                    r_res_new;
    logic                                r_res_added;

    logic [IDX_W-1:0]                    w_ridx;
    logic [CNT_W-1:0]                    w_lim;
    logic [CNT_W-1:0]                    w_grown;
    logic [CNT_W-1:0]                    w_trim;
    logic [CNT_W-1:0]                    w_rank;

    assign w_ridx = r_idx[IDX_W-1:0];

    // A register value above the physical depth acts as the depth.
    assign w_lim = (int'(r_max_entries) > TD) ? CNT_W'(TD) : CNT_W'(r_max_entries);

    assign o_sts.find_end = (r_idx >= r_count);
    assign o_sts.find_hit = (r_ids[w_ridx] == r_id);
    assign o_sts.srch_end = (r_idx >= r_lim);
    assign o_sts.srch_hit = (r_idx >= r_count) || (r_score > r_scores[w_ridx]);
    assign o_sts.out_free = !r_res_valid || i_out_ready;

    // Count after insertion and trim, and the rank that results.
    assign w_grown = (r_placed && (r_count < CNT_W'(TD))) ? r_count + CNT_W'(1) : r_count;
    assign w_trim  = (w_grown > r_lim) ? r_lim : w_grown;
    assign w_rank  = r_placed ? CNT_W'(r_pos) + CNT_W'(1) : '0;

    // Every slot moves only to or from its neighbor, so removal and insertion are each
    // a single registered shift of the table.
    always_comb begin
        n_ids    = r_ids;
        n_scores = r_scores;
        if (i_cmd.remove && r_found) begin
            for (int j = 0; j < TD - 1; j++) begin
                if (IDX_W'(j) >= r_fidx) begin
                    n_ids[j]    = r_ids[j + 1];
                    n_scores[j] = r_scores[j + 1];
                end
            end
        end else if (i_cmd.insert && r_placed) begin
            for (int j = 1; j < TD; j++) begin
                if (IDX_W'(j) > r_pos) begin
                    n_ids[j]    = r_ids[j - 1];
                    n_scores[j] = r_scores[j - 1];
                end
            end
            n_ids[r_pos]    = r_id;
            n_scores[r_pos] = r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids    <= n_ids;
        r_scores <= n_scores;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= tkst_pkg::MAXE_RESET;
            r_count       <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            if (i_cmd.remove && r_found) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.insert) begin
                r_count <= w_trim;
            end
            if (i_cmd.finish) begin
                r_res_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_id     <= i_player_id;
            r_score  <= i_score;
            r_lim    <= w_lim;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_placed <= 1'b0;
        end
        if (i_cmd.find) begin
            if (!o_sts.find_end && o_sts.find_hit) begin
                r_found <= 1'b1;
                r_fidx  <= w_ridx;
            end
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.remove) begin
            r_idx <= '0;
        end
        if (i_cmd.search) begin
            if (!o_sts.srch_end && o_sts.srch_hit) begin
                r_placed <= 1'b1;
                r_pos    <= w_ridx;
            end
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.insert) begin
            r_new_rank <= (w_rank > w_trim) ? '0 : w_rank;
        end
        if (i_cmd.finish) begin
            r_res_old   <= r_found ? POS_W'(CNT_W'(r_fidx) + CNT_W'(1)) : '0;
            r_res_new   <= POS_W'(r_new_rank);
            r_res_added <= (r_new_rank != '0);
        end
    end

    assign o_out_valid    = r_res_valid;
    assign o_old_position = r_res_old;
    assign o_new_position = r_res_new;
    assign o_added        = r_res_added;

endmodule

`default_nettype wire

// ===== hw/rtl/tkst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkst_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [tkst_pkg::POS_W-1:0] i_old_position,
    input wire logic [tkst_pkg::POS_W-1:0] i_new_position,
    input wire logic                       i_added
);

    // A stalled report holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_old_position)
            && $stable(i_new_position) && $stable(i_added))
        else $error("stalled report changed");

    // The added flag matches a nonzero new rank.
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_added == (i_new_position != '0)))
        else $error("added flag disagrees with new position");

    // Ranks never exceed the table depth.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_old_position) <= tkst_pkg::TABLE_DEPTH)
            && (int'(i_new_position) <= tkst_pkg::TABLE_DEPTH))
        else $error("rank beyond table depth");

    // The block is not ready again in the cycle after it takes an update.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("update accepted while busy");

endmodule

bind top_k_score_table_core tkst_checker u_tkst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_old_position (o_out.old_position),
    .i_new_position (o_out.new_position),
    .i_added        (o_out.added)
);

`default_nettype wire
